>>> rtl/etd_pkg.sv
// Shared constants for the envelope trigger detector.
// Holds register widths, register indexes and reset values; no dependencies.

package etd_pkg;

  localparam int REG_W               = 16;
  localparam int CFG_IDX_W           = 3;
  localparam int DEFAULT_SAMPLE_BITS = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH_MAX   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH_ON    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH_OFF   = 3'd4;

  localparam logic [REG_W-1:0] ATTACK_GAIN_RST  = 16'd64855;
  localparam logic [REG_W-1:0] RELEASE_GAIN_RST = 16'd65522;
  localparam logic [REG_W-1:0] THRESH_MAX_RST   = 16'd328;
  localparam logic [REG_W-1:0] THRESH_ON_RST    = 16'd328;
  localparam logic [REG_W-1:0] THRESH_OFF_RST   = 16'd328;

endpackage

>>> rtl/etd_serial_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle while step_i is high.
// Depends on etd_pkg for the multiplier width.

module etd_serial_mul import etd_pkg::*; #(
  parameter int A_W = DEFAULT_SAMPLE_BITS
) (
  input  logic                   clk_i,
  input  logic                   start_i,
  input  logic                   step_i,
  input  logic [A_W-1:0]         a_i,
  input  logic [REG_W-1:0]       b_i,
  output logic [A_W+REG_W-1:0]   prod_o
);

  logic [A_W-1:0]   a_q;
  logic [A_W-1:0]   acc_q;
  logic [REG_W-1:0] b_q;
  logic [A_W:0]     sum;

  assign sum    = {1'b0, acc_q} + (b_q[0] ? {1'b0, a_q} : '0);
  assign prod_o = {acc_q, b_q};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      acc_q <= '0;
      b_q   <= b_i;
    end else if (step_i) begin
      acc_q <= sum[A_W:1];
      b_q   <= {sum[0], b_q[REG_W-1:1]};
    end
  end

endmodule

>>> rtl/etd_serial_div.sv
// Bit-serial restoring divider, one quotient bit per cycle while step_i is high.
// The quotient is known to fit in W bits. Depends on etd_pkg.

module etd_serial_div import etd_pkg::*; #(
  parameter int W = DEFAULT_SAMPLE_BITS
) (
  input  logic                 clk_i,
  input  logic                 start_i,
  input  logic                 step_i,
  input  logic [REG_W+W-1:0]   num_i,
  input  logic [W-1:0]         den_i,
  output logic [W-1:0]         quo_o
);

  logic [W-1:0] rem_q;
  logic [W-1:0] lq_q;
  logic [W-1:0] den_q;
  logic [W:0]   trial;
  logic         ge;

  assign trial = {rem_q, lq_q[W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign quo_o = lq_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= W'(num_i[REG_W+W-1:W]);
      lq_q  <= num_i[W-1:0];
      den_q <= den_i;
    end else if (step_i) begin
      rem_q <= ge ? W'(trial - {1'b0, den_q}) : trial[W-1:0];
      lq_q  <= {lq_q[W-2:0], ge};
    end
  end

endmodule

>>> rtl/envelope_trigger_detector.sv
// Attack/release envelope follower with buffer peak, limiter level and trigger.
// Depends on etd_pkg, etd_serial_mul and etd_serial_div.
//
// One sample at a time is processed: a request is taken while idle, the
// products are formed, and the new envelope is evaluated; only when it is
// above thresh_max is the limiter quotient then divided out. The envelope
// gain product is formed by a bit-serial multiplier over the 16 gain bits,
// alongside the thresh_max product; the limiter quotient then comes from a
// bit-serial divider at one bit per cycle. A finished result waits in the
// output register, so a new request is taken even while the output is stalled.

module envelope_trigger_detector import etd_pkg::*; #(
  parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [REG_W-1:0]              cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          last_of_buffer_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          trig_active_o,
  output logic                          went_on_o,
  output logic                          went_off_o,
  output logic                          buffer_done_o,
  output logic [SAMPLE_BITS-1:0]        peak_level_o,
  output logic [SAMPLE_BITS-1:0]        limiter_level_o,
  output logic [SAMPLE_BITS-1:0]        envelope_level_o
);

  localparam int STEPS_MAX = (SAMPLE_BITS > REG_W) ? SAMPLE_BITS : REG_W;
  localparam int CNT_W     = $clog2(STEPS_MAX);
  localparam int CMP_W     = STEPS_MAX;
  localparam int PROD_W    = SAMPLE_BITS + REG_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_EVAL = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]             state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;

  logic [REG_W-1:0]       attack_gain_q, release_gain_q;
  logic [REG_W-1:0]       thresh_max_q, thresh_on_q, thresh_off_q;

  logic [SAMPLE_BITS-1:0] env_q, peak_q, limit_q;
  logic                   flag_q, may_on_q, may_off_q, buf_start_q;
  logic                   out_valid_q;

  logic [SAMPLE_BITS-1:0] m_q;
  logic                   last_q, attack_q, use_div_q;

  logic                   trig_q, on_q, off_q, done_q;
  logic [SAMPLE_BITS-1:0] peak_out_q, limit_out_q, env_out_q;

  logic [SAMPLE_BITS-1:0] samp_u, mag, diff, q_env, env_new, lim, peak_new, limit_new;
  logic [REG_W-1:0]       gain;
  logic                   attack, in_acc, go_div, out_free, done_fire;
  logic                   on_ev, off_ev, flag_new;
  logic [PROD_W-1:0]      env_prod, lim_prod;
  logic [SAMPLE_BITS-1:0] quo;

  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);

  assign samp_u = sample_i;
  assign mag    = samp_u[SAMPLE_BITS-1] ? SAMPLE_BITS'(~samp_u + 1'b1) : samp_u;
  assign attack = env_q < mag;
  assign diff   = attack ? mag - env_q : env_q - mag;
  assign gain   = attack ? attack_gain_q : release_gain_q;

  etd_serial_mul #(.A_W(SAMPLE_BITS)) u_env_mul (
    .clk_i   (clk_i),
    .start_i (in_acc),
    .step_i  (state_q == ST_MUL),
    .a_i     (diff),
    .b_i     (gain),
    .prod_o  (env_prod)
  );

  etd_serial_mul #(.A_W(SAMPLE_BITS)) u_lim_mul (
    .clk_i   (clk_i),
    .start_i (in_acc),
    .step_i  (state_q == ST_MUL),
    .a_i     (mag),
    .b_i     (thresh_max_q),
    .prod_o  (lim_prod)
  );

  assign q_env   = env_prod[PROD_W-1:REG_W];
  assign env_new = attack_q ? m_q - q_env : m_q + q_env;
  assign go_div  = CMP_W'(env_new) > CMP_W'(thresh_max_q);

  etd_serial_div #(.W(SAMPLE_BITS)) u_lim_div (
    .clk_i   (clk_i),
    .start_i ((state_q == ST_EVAL) && go_div),
    .step_i  (state_q == ST_DIV),
    .num_i   (lim_prod),
    .den_i   (env_new),
    .quo_o   (quo)
  );

  assign lim       = use_div_q ? quo : m_q;
  assign peak_new  = (m_q > peak_q) ? m_q : peak_q;
  assign limit_new = (lim > limit_q) ? lim : limit_q;
  assign on_ev     = may_on_q && (CMP_W'(env_q) > CMP_W'(thresh_on_q));
  assign off_ev    = may_off_q && (CMP_W'(env_q) < CMP_W'(thresh_off_q));
  assign flag_new  = off_ev ? 1'b0 : (on_ev | flag_q);

  assign out_free  = !out_valid_q || !out_stall_i;
  assign done_fire = (state_q == ST_DONE) && out_free;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_MUL;
          cnt_d   = '0;
        end
      end
      ST_MUL: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(REG_W - 1)) begin
          state_d = ST_EVAL;
          cnt_d   = '0;
        end
      end
      ST_EVAL: begin
        state_d = go_div ? ST_DIV : ST_DONE;
        cnt_d   = '0;
      end
      ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(SAMPLE_BITS - 1)) begin
          state_d = ST_DONE;
          cnt_d   = '0;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      cnt_q          <= '0;
      attack_gain_q  <= ATTACK_GAIN_RST;
      release_gain_q <= RELEASE_GAIN_RST;
      thresh_max_q   <= THRESH_MAX_RST;
      thresh_on_q    <= THRESH_ON_RST;
      thresh_off_q   <= THRESH_OFF_RST;
      env_q          <= '0;
      peak_q         <= '0;
      limit_q        <= '0;
      flag_q         <= 1'b0;
      may_on_q       <= 1'b1;
      may_off_q      <= 1'b0;
      buf_start_q    <= 1'b1;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ATTACK_GAIN:  attack_gain_q  <= cfg_data_i;
          CFG_RELEASE_GAIN: release_gain_q <= cfg_data_i;
          CFG_THRESH_MAX:   thresh_max_q   <= cfg_data_i;
          CFG_THRESH_ON:    thresh_on_q    <= cfg_data_i;
          CFG_THRESH_OFF:   thresh_off_q   <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (in_acc && buf_start_q) begin
        peak_q    <= '0;
        limit_q   <= '0;
        may_on_q  <= !flag_q;
        may_off_q <= flag_q;
      end
      if (state_q == ST_EVAL) begin
        env_q <= env_new;
      end
      if (done_fire) begin
        peak_q      <= peak_new;
        limit_q     <= limit_new;
        flag_q      <= flag_new;
        buf_start_q <= last_q;
        if (on_ev) begin
          may_on_q <= 1'b0;
        end
        if (off_ev) begin
          may_off_q <= 1'b0;
        end
      end
      if (done_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      m_q      <= mag;
      last_q   <= last_of_buffer_i;
      attack_q <= attack;
    end
    if (state_q == ST_EVAL) begin
      use_div_q <= go_div;
    end
    if (done_fire) begin
      trig_q      <= flag_new;
      on_q        <= on_ev;
      off_q       <= off_ev;
      done_q      <= last_q;
      peak_out_q  <= last_q ? peak_new : '0;
      limit_out_q <= last_q ? limit_new : '0;
      env_out_q   <= last_q ? env_q : '0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign trig_active_o    = trig_q;
  assign went_on_o        = on_q;
  assign went_off_o       = off_q;
  assign buffer_done_o    = done_q;
  assign peak_level_o     = peak_out_q;
  assign limiter_level_o  = limit_out_q;
  assign envelope_level_o = env_out_q;

endmodule

>>> tb/envelope_trigger_detector_tb.sv
// Self-checking testbench for envelope_trigger_detector: directed, backpressure and
// random buffer tests against a built-in envelope, limiter and trigger predictor.
// Depends on etd_pkg and the envelope_trigger_detector RTL.
`timescale 1ns / 100ps

module envelope_trigger_detector_tb;
  import etd_pkg::*;

  localparam int SB             = DEFAULT_SAMPLE_BITS;
  localparam int MAX_POS        = (1 << (SB - 1)) - 1;
  localparam int SETTLE_CYCLES  = 2 * (19 + SB) + 10;
  localparam int HOLD_CYCLES    = 200;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd5;

  typedef enum int {AMP_FULL, AMP_QUIET, AMP_EDGE, AMP_LOUD} amp_kind_e;

  typedef struct packed {
    logic          trig_active;
    logic          went_on;
    logic          went_off;
    logic          buffer_done;
    logic [SB-1:0] peak_level;
    logic [SB-1:0] limiter_level;
    logic [SB-1:0] envelope_level;
  } level_result_t;

  logic                 clk_i            = 1'b0;
  logic                 rst_ni           = 1'b0;
  logic                 cfg_we_i         = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i        = '0;
  logic [REG_W-1:0]     cfg_data_i       = '0;
  logic                 in_valid_i       = 1'b0;
  logic                 in_stall_o;
  logic signed [SB-1:0] sample_i         = '0;
  logic                 last_of_buffer_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i      = 1'b0;
  logic                 trig_active_o;
  logic                 went_on_o;
  logic                 went_off_o;
  logic                 buffer_done_o;
  logic [SB-1:0]        peak_level_o;
  logic [SB-1:0]        limiter_level_o;
  logic [SB-1:0]        envelope_level_o;

  level_result_t expected_levels[$];
  int            errors        = 0;
  logic          send_steady   = 1'b0;
  logic          recv_steady   = 1'b0;
  logic          hold_request  = 1'b0;

  longint attack_reg  = longint'(ATTACK_GAIN_RST);
  longint release_reg = longint'(RELEASE_GAIN_RST);
  longint tmax_reg    = longint'(THRESH_MAX_RST);
  longint ton_reg     = longint'(THRESH_ON_RST);
  longint toff_reg    = longint'(THRESH_OFF_RST);

  longint env_lvl     = 0;
  longint buf_peak    = 0;
  longint buf_limit   = 0;
  logic   trig_on     = 1'b0;
  logic   on_allowed  = 1'b1;
  logic   off_allowed = 1'b0;
  logic   buf_first   = 1'b1;

  envelope_trigger_detector #(
    .SAMPLE_BITS(SB)
  ) DUT (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .sample_i,
    .last_of_buffer_i,
    .out_valid_o,
    .out_stall_i,
    .trig_active_o,
    .went_on_o,
    .went_off_o,
    .buffer_done_o,
    .peak_level_o,
    .limiter_level_o,
    .envelope_level_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic level_result_t follow_envelope(input logic signed [SB-1:0] smp,
                                                    input logic last);
    longint        mag;
    longint        lim_now;
    level_result_t r;
    mag = (smp < 0) ? -longint'(smp) : longint'(smp);
    if (buf_first) begin
      buf_peak    = 0;
      buf_limit   = 0;
      on_allowed  = !trig_on;
      off_allowed = trig_on;
    end
    if (env_lvl < mag) begin
      env_lvl = mag - ((attack_reg * (mag - env_lvl)) >> 16);
    end else begin
      env_lvl = mag + ((release_reg * (env_lvl - mag)) >> 16);
    end
    if (mag > buf_peak) begin
      buf_peak = mag;
    end
    lim_now = (env_lvl > tmax_reg) ? (tmax_reg * mag) / env_lvl : mag;
    if (lim_now > buf_limit) begin
      buf_limit = lim_now;
    end
    r = '0;
    if (on_allowed && env_lvl > ton_reg) begin
      on_allowed = 1'b0;
      trig_on    = 1'b1;
      r.went_on  = 1'b1;
    end
    if (off_allowed && env_lvl < toff_reg) begin
      off_allowed = 1'b0;
      trig_on     = 1'b0;
      r.went_off  = 1'b1;
    end
    r.trig_active = trig_on;
    r.buffer_done = last;
    if (last) begin
      r.peak_level     = SB'(buf_peak);
      r.limiter_level  = SB'(buf_limit);
      r.envelope_level = SB'(env_lvl);
    end
    buf_first = last;
    return r;
  endfunction

  function automatic logic signed [SB-1:0] pick_sample(input amp_kind_e kind);
    int v;
    case (kind)
      AMP_QUIET: v = int'($urandom_range(0, 1200)) - 600;
      AMP_EDGE: begin
        case ($urandom_range(0, 4))
          0:       v = -(MAX_POS + 1);
          1:       v = MAX_POS;
          2:       v = 0;
          3:       v = -1;
          default: v = 1;
        endcase
      end
      AMP_LOUD: begin
        v = $urandom_range(8000, MAX_POS);
        if ($urandom_range(0, 1)) begin
          v = -v - $urandom_range(0, 1);
        end
      end
      default: v = $urandom;
    endcase
    return SB'(v);
  endfunction

  function automatic logic [REG_W-1:0] rand_gain();
    case ($urandom_range(0, 3))
      0:       return REG_W'($urandom_range(0, 65535));
      1:       return REG_W'($urandom_range(60000, 65535));
      2:       return REG_W'($urandom_range(30000, 60000));
      default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  function automatic logic [REG_W-1:0] rand_level();
    case ($urandom_range(0, 7))
      0, 1:    return REG_W'($urandom_range(0, 32768));
      2:       return REG_W'($urandom_range(32769, 65535));
      default: return REG_W'($urandom_range(0, 3000));
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_ATTACK_GAIN:  attack_reg  = longint'(val);
      CFG_RELEASE_GAIN: release_reg = longint'(val);
      CFG_THRESH_MAX:   tmax_reg    = longint'(val);
      CFG_THRESH_ON:    ton_reg     = longint'(val);
      CFG_THRESH_OFF:   toff_reg    = longint'(val);
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [REG_W-1:0] atk, input logic [REG_W-1:0] rel,
                           input logic [REG_W-1:0] tmax, input logic [REG_W-1:0] ton,
                           input logic [REG_W-1:0] toff);
    write_reg(CFG_ATTACK_GAIN, atk);
    write_reg(CFG_RELEASE_GAIN, rel);
    write_reg(CFG_THRESH_MAX, tmax);
    write_reg(CFG_THRESH_ON, ton);
    write_reg(CFG_THRESH_OFF, toff);
  endtask

  task automatic send_sample(input logic signed [SB-1:0] smp, input logic last);
    int gap;
    gap = send_steady ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    sample_i         <= smp;
    last_of_buffer_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    expected_levels.insert(expected_levels.size(), follow_envelope(smp, last));
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_default_settings();
    send_sample(16'sd0, 1'b0);
    send_sample(SB'(MAX_POS), 1'b0);
    send_sample(SB'(-(MAX_POS + 1)), 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd1, 1'b1);
    send_sample(SB'(-(MAX_POS + 1)), 1'b1);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b1);
    settle();
  endtask

  task automatic test_register_extremes();
    write_all(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd32768);
    write_reg(CFG_UNUSED_IDX, 16'hFFFF);
    send_sample(16'sd100, 1'b0);
    send_sample(SB'(-(MAX_POS + 1)), 1'b0);
    send_sample(16'sd0, 1'b1);
    send_sample(16'sd5, 1'b1);
    send_sample(16'sd0, 1'b1);
    settle();
    write_all(16'hFFFF, 16'hFFFF, 16'd32768, 16'hFFFF, 16'h0000);
    send_sample(SB'(-(MAX_POS + 1)), 1'b0);
    send_sample(SB'(MAX_POS), 1'b0);
    send_sample(16'sd0, 1'b1);
    send_sample(16'sd1, 1'b1);
    settle();
  endtask

  task automatic test_output_backpressure();
    write_all(ATTACK_GAIN_RST, RELEASE_GAIN_RST, THRESH_MAX_RST, THRESH_ON_RST,
              THRESH_OFF_RST);
    send_steady  = 1'b1;
    hold_request = 1'b1;
    for (int k = 0; k < 12; k++) begin
      send_sample(pick_sample(AMP_LOUD), k % 4 == 3);
    end
    send_steady = 1'b0;
    settle();
  endtask

  task automatic test_random_buffers();
    int        sent;
    int        blen;
    logic      noisy;
    amp_kind_e kind;
    for (int ph = 0; ph < 6; ph++) begin
      write_all(rand_gain(), rand_gain(), rand_level(), rand_level(), rand_level());
      sent = 0;
      while (sent < 92) begin
        blen        = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(1, 12);
        kind        = amp_kind_e'($urandom_range(0, 3));
        noisy       = ($urandom_range(0, 7) == 0);
        send_steady = ($urandom_range(0, 5) == 0);
        recv_steady = ($urandom_range(0, 5) == 0);
        for (int k = 0; k < blen; k++) begin
          send_sample(pick_sample(kind), noisy ? 1'($urandom_range(0, 1)) : (k == blen - 1));
        end
        sent += blen;
      end
      send_steady = 1'b0;
      recv_steady = 1'b0;
      settle();
    end
  endtask

  initial begin : result_sink
    int gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_request) begin
        gap          = HOLD_CYCLES;
        hold_request = 1'b0;
      end else begin
        gap = recv_steady ? 0 : $urandom_range(0, 19);
      end
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o || out_stall_i);
    end
  end

  always @(posedge clk_i) begin : result_check
    level_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_levels.size() == 0) begin
        $error("result with no request pending");
        errors++;
      end else begin
        exp_r = expected_levels.pop_front();
        if (trig_active_o !== exp_r.trig_active) begin
          $error("trig_active expected %0d actual %0d", exp_r.trig_active, trig_active_o);
          errors++;
        end
        if (went_on_o !== exp_r.went_on) begin
          $error("went_on expected %0d actual %0d", exp_r.went_on, went_on_o);
          errors++;
        end
        if (went_off_o !== exp_r.went_off) begin
          $error("went_off expected %0d actual %0d", exp_r.went_off, went_off_o);
          errors++;
        end
        if (buffer_done_o !== exp_r.buffer_done) begin
          $error("buffer_done expected %0d actual %0d", exp_r.buffer_done, buffer_done_o);
          errors++;
        end
        if (peak_level_o !== exp_r.peak_level) begin
          $error("peak_level expected %0d actual %0d", exp_r.peak_level, peak_level_o);
          errors++;
        end
        if (limiter_level_o !== exp_r.limiter_level) begin
          $error("limiter_level expected %0d actual %0d", exp_r.limiter_level,
                 limiter_level_o);
          errors++;
        end
        if (envelope_level_o !== exp_r.envelope_level) begin
          $error("envelope_level expected %0d actual %0d", exp_r.envelope_level,
                 envelope_level_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_settings();
    test_register_extremes();
    test_output_backpressure();
    test_random_buffers();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/etd_pkg.sv
rtl/etd_serial_mul.sv
rtl/etd_serial_div.sv
rtl/envelope_trigger_detector.sv
tb/envelope_trigger_detector_tb.sv
